[rtl/core/wsfse_pkg.sv]
// Shared types and constants for the LED chain symbol encoder.
`default_nettype none
package wsfse_pkg;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_START = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	typedef logic [1:0] led_idx_t;
	typedef logic [7:0] byte_t;
	typedef logic [23:0] color_t;

	localparam int CFG_IW = 1;
	typedef logic [CFG_IW-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ONE_SYMBOL  = 1'b0;
	localparam cfg_idx_t CFG_ZERO_SYMBOL = 1'b1;

	localparam byte_t ONE_SYMBOL_RST  = 8'd248;
	localparam byte_t ZERO_SYMBOL_RST = 8'd192;

	localparam logic [4:0] BIT_LAST = 5'd23;
	localparam byte_t IDLE_BYTE = 8'h00;

endpackage
`default_nettype wire

[rtl/core/wsfse_if.sv]
// Valid/ready channel interfaces: input items, result items, register writes.
`default_nettype none
interface wsfse_in_if;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	wsfse_pkg::led_idx_t led_index;
	wsfse_pkg::byte_t    red;
	wsfse_pkg::byte_t    green;
	wsfse_pkg::byte_t    blue;

	modport source (output valid, func, led_index, red, green, blue, input ready);
	modport sink (input valid, func, led_index, red, green, blue, output ready);
endinterface

interface wsfse_out_if;
	logic             valid;
	logic             ready;
	logic             accepted;
	logic             symbol_valid;
	wsfse_pkg::byte_t symbol;
	logic             last_symbol;
	logic             busy_res;

	modport source (output valid, accepted, symbol_valid, symbol, last_symbol, busy_res,
		input ready);
	modport sink (input valid, accepted, symbol_valid, symbol, last_symbol, busy_res,
		output ready);
endinterface

interface wsfse_cfg_if;
	logic                valid;
	logic                ready;
	wsfse_pkg::cfg_idx_t index;
	wsfse_pkg::byte_t    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/ws2812_frame_symbol_encoder.sv]
// Frame symbol encoder: color store in a synchronous memory, one serial byte per tick.
//
// Channels: item (sink) carries commands: write a color, start a frame, or tick.
// result (source) returns one word per item: accepted, symbol_valid, symbol,
// last_symbol and busy_res. cfg (sink) writes one_symbol (index 0) and
// zero_symbol (index 1); it is always ready and may be written at any time.
// A frame is RESET_BYTES zero bytes followed by 24 symbol bytes per LED,
// green-red-blue, most significant bit first; one tick emits one byte.
// Each item is captured in the idle state and executed in the EXEC state, which
// forms the byte from the registered read of the color memory and updates the
// frame counters. Items are taken one at a time: no new item is taken until the
// previous one has been executed and its result word registered.
// A new item is taken while the previous result word is being taken in the same
// cycle; if the receiver stalls, the result word holds and no further item is
// accepted. Reset clears the frame state, restores the symbol registers to
// 248 and 192, and marks every color entry empty (reads as zero) at once.
`default_nettype none
module ws2812_frame_symbol_encoder #(
	parameter int LED_COUNT   = 4,
	parameter int RESET_BYTES = 48
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wsfse_in_if.sink    item,
	wsfse_out_if.source result,
	wsfse_cfg_if.sink   cfg
);
	import wsfse_pkg::*;

	localparam int MEM_DEPTH = (LED_COUNT < 4) ? LED_COUNT : 4;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int RST_W     = (RESET_BYTES > 0) ? $clog2(RESET_BYTES + 1) : 1;

	localparam logic [RST_W-1:0] RST_END  = RST_W'(RESET_BYTES);
	localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT - 1);
	localparam logic [8:0]       LED_NUM  = 9'(LED_COUNT);
	localparam logic [8:0]       MEM_NUM  = 9'(MEM_DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	// captured command
	logic [1:0]  func_q;
	led_idx_t    idx_q;
	color_t      color_q;

	// frame state
	logic             busy_q;
	logic [RST_W-1:0] rst_cnt_q;
	logic [LED_W-1:0] led_q;
	logic [4:0]       bit_q;

	byte_t one_sym_q;
	byte_t zero_sym_q;

	// color memory and per-entry written flags
	color_t mem [MEM_DEPTH];
	logic   vld_q [MEM_DEPTH];
	color_t rd_data_s1;
	logic   rd_ok_s1;

	// result word
	logic  out_vld_q;
	logic  acc_q;
	logic  sym_vld_q;
	byte_t sym_q;
	logic  last_q;
	logic  busy_res_q;

	logic             take;
	logic             mem_we;
	logic [MEM_AW-1:0] wr_addr;
	logic [MEM_AW-1:0] rd_addr;
	logic             rd_in_range;
	logic             in_rst;
	logic             frame_end;
	logic             data_bit;

	// next-state values
	logic             acc_d;
	logic             sym_vld_d;
	byte_t            sym_d;
	logic             last_d;
	logic             busy_d;
	logic [RST_W-1:0] rst_cnt_d;
	logic [LED_W-1:0] led_d;
	logic [4:0]       bit_d;

	assign take         = item.valid && item.ready;
	assign item.ready   = (state_q == ST_IDLE) && (!out_vld_q || result.ready);
	assign cfg.ready    = 1'b1;

	assign result.valid        = out_vld_q;
	assign result.accepted     = acc_q;
	assign result.symbol_valid = sym_vld_q;
	assign result.symbol       = sym_q;
	assign result.last_symbol  = last_q;
	assign result.busy_res     = busy_res_q;

	assign wr_addr     = idx_q[MEM_AW-1:0];
	assign rd_addr     = led_q[MEM_AW-1:0];
	assign rd_in_range = (9'(led_q) < MEM_NUM);
	assign in_rst      = (rst_cnt_q != RST_END);
	assign frame_end   = (led_q == LED_LAST) && (bit_q == BIT_LAST);
	assign data_bit    = rd_ok_s1 && rd_data_s1[BIT_LAST - bit_q];

	always_comb begin
		acc_d     = 1'b0;
		sym_vld_d = 1'b0;
		sym_d     = IDLE_BYTE;
		last_d    = 1'b0;
		busy_d    = busy_q;
		rst_cnt_d = rst_cnt_q;
		led_d     = led_q;
		bit_d     = bit_q;
		mem_we    = 1'b0;
		case (func_q)
			FUNC_WRITE: begin
				if (!busy_q && ({7'd0, idx_q} < LED_NUM)) begin
					mem_we = 1'b1;
					acc_d  = 1'b1;
				end
			end
			FUNC_START: begin
				if (!busy_q) begin
					busy_d    = 1'b1;
					rst_cnt_d = '0;
					led_d     = '0;
					bit_d     = '0;
					acc_d     = 1'b1;
				end
			end
			FUNC_TICK: begin
				if (busy_q) begin
					sym_vld_d = 1'b1;
					if (in_rst) begin
						rst_cnt_d = rst_cnt_q + 1'b1;
					end else begin
						sym_d = data_bit ? one_sym_q : zero_sym_q;
						if (frame_end) begin
							// close the frame and rewind
							last_d    = 1'b1;
							busy_d    = 1'b0;
							rst_cnt_d = '0;
							led_d     = '0;
							bit_d     = '0;
						end else if (bit_q == BIT_LAST) begin
							bit_d = '0;
							led_d = led_q + 1'b1;
						end else begin
							bit_d = bit_q + 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			busy_q     <= 1'b0;
			rst_cnt_q  <= '0;
			led_q      <= '0;
			bit_q      <= '0;
			out_vld_q  <= 1'b0;
			one_sym_q  <= ONE_SYMBOL_RST;
			zero_sym_q <= ZERO_SYMBOL_RST;
			for (int i = 0; i < MEM_DEPTH; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_ONE_SYMBOL:  one_sym_q  <= cfg.data;
					CFG_ZERO_SYMBOL: zero_sym_q <= cfg.data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (result.ready) begin
						out_vld_q <= 1'b0;
					end
					if (take) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q   <= ST_IDLE;
					out_vld_q <= 1'b1;
					busy_q    <= busy_d;
					rst_cnt_q <= rst_cnt_d;
					led_q     <= led_d;
					bit_q     <= bit_d;
					if (mem_we) begin
						vld_q[wr_addr] <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command capture, result payload and the color memory
	always_ff @(posedge clk) begin
		if (take) begin
			func_q  <= item.func;
			idx_q   <= item.led_index;
			color_q <= {item.green, item.red, item.blue};
		end
		if (state_q == ST_EXEC) begin
			acc_q      <= acc_d;
			sym_vld_q  <= sym_vld_d;
			sym_q      <= sym_d;
			last_q     <= last_d;
			busy_res_q <= busy_d;
		end
		if ((state_q == ST_EXEC) && mem_we) begin
			mem[wr_addr] <= color_q;
		end
		rd_data_s1 <= mem[rd_addr];
		rd_ok_s1   <= rd_in_range && vld_q[rd_addr];
	end

endmodule
`default_nettype wire
